// ===== hw/rtl/vcfp_pkg.sv =====
// vcfp_pkg: shared types, constants and helpers of the video command front end
`timescale 1ns / 1ps

package vcfp_pkg;

  // command fifo geometry
  localparam int FifoDepth = 1024;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int FillW     = $clog2(FifoDepth + 1);

  // stream payload widths
  localparam int InDataW  = 48;
  localparam int InUserW  = 2;
  localparam int OutDataW = 280;
  localparam int MixW     = 20;

  // reset values of the display registers
  localparam logic [31:0] PageReset = 32'h1800_0000;
  localparam logic [31:0] ModeReset = 32'h0000_0007;

  // bus operation carried in tuser
  typedef enum logic [1:0] {
    OpWrite = 2'd0,
    OpRead  = 2'd1,
    OpVsync = 2'd2,
    OpNone  = 2'd3
  } bus_op_e;

  // command opcodes, low byte of a command word
  localparam logic [7:0] CmdFrontA = 8'h00;
  localparam logic [7:0] CmdMode   = 8'h02;
  localparam logic [7:0] CmdCache  = 8'h03;
  localparam logic [7:0] CmdScan   = 8'h04;
  localparam logic [7:0] CmdPix    = 8'h05;
  localparam logic [7:0] CmdBackA  = 8'h06;
  localparam logic [7:0] CmdSwapA  = 8'h07;
  localparam logic [7:0] CmdFrontB = 8'h09;
  localparam logic [7:0] CmdBackB  = 8'h0A;
  localparam logic [7:0] CmdSwapB  = 8'h0B;
  localparam logic [7:0] CmdMix    = 8'h0C;

  localparam int SwapNowBit   = 8;
  localparam int StatBlankBit = 0;
  localparam int StatFifoBit  = 11;

  typedef enum logic [1:0] {
    StIdle,
    StDrain,
    StDrainWait,
    StResult
  } state_e;

  // advance a fifo pointer with wrap at the depth
  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] ptr);
    logic [PtrW-1:0] res;
    if (ptr == PtrW'(FifoDepth - 1)) begin
      res = '0;
    end else begin
      res = ptr + PtrW'(1);
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/vcfp_ram.sv =====
// vcfp_ram: generic single write, single read ram with registered read data
`timescale 1ns / 1ps

module vcfp_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/video_command_fifo_processor_unit.sv =====
// video_command_fifo_processor_unit: command fifo and decoder of the video unit
`timescale 1ns / 1ps

// usage
// - slave stream: one transaction per bus access; s_tuser_i carries the
//   operation (write, read, vsync tick), s_tdata_i the byte offset and the
//   write word; a write queues the word in a 1024 entry command ram
// - master stream: one result transaction per accepted input, holding the
//   status word, all display registers and the overflow flag
// - after a write or a vsync tick the fifo is drained one word at a time
//   (ram read, then decode) until empty or a swap waits for vsync
// - m_tvalid_o rises once the result state loads the output register; a read
//   goes there straight, a write or vsync tick first runs the drain loop;
//   throughput is set by the drain loop through the single ram read port
// - only one transaction is in work at a time; the next input is taken as
//   soon as the decoder is back in idle, even while the previous result
//   still sits in the output register
// - a receiver stall holds the result register and the decoder waits in its
//   result state until the register frees up
// - reset clears pointers and status and presets display registers at once;
//   the ram needs no clearing since a word is only read after it was written
module video_command_fifo_processor_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  // byte_offset [11:0], write_data [43:12], zero fill [47:44]
  input  logic [vcfp_pkg::InDataW-1:0]  s_tdata_i,
  // opcode [1:0]
  input  logic [vcfp_pkg::InUserW-1:0]  s_tuser_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // read_data [31:0], scan_page_a [63:32], back_page_a [95:64],
  // scan_page_b [127:96], back_page_b [159:128], video_mode [191:160],
  // scanout_offset [223:192], pixel_offset [255:224], layer_b_on [256],
  // blend_mode [259:257], color_key [275:260], fifo_overflow [276],
  // zero fill [279:277]
  output logic [vcfp_pkg::OutDataW-1:0] m_tdata_o
);

  localparam int PtrW  = vcfp_pkg::PtrW;
  localparam int FillW = vcfp_pkg::FillW;

  vcfp_pkg::state_e state_q, state_d;

  // fifo control
  logic [PtrW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             param_q, param_d;
  logic [7:0]       held_op_q, held_op_d;
  logic             blank_q, blank_d;
  logic             wait_a_q, wait_a_d, wait_b_q, wait_b_d;

  // display registers
  logic [31:0] front_a_q, front_a_d, back_a_q, back_a_d;
  logic [31:0] front_b_q, front_b_d, back_b_q, back_b_d;
  logic [31:0] mode_q, mode_d, scan_q, scan_d, pix_q, pix_d;
  logic [vcfp_pkg::MixW-1:0] mix_q, mix_d;

  // per transaction result pieces
  logic [31:0] rd_q, rd_d;
  logic        ovf_q, ovf_d;

  // output register
  logic                          m_valid_q, m_valid_d;
  logic [vcfp_pkg::OutDataW-1:0] m_data_q;
  logic                          out_load;

  // ram ports
  logic        ram_we, ram_re;
  logic [31:0] ram_rdata;

  logic        in_acc;
  logic [11:0] in_offset;
  logic [31:0] in_word;
  logic [31:0] fifo_word;

  assign in_offset = s_tdata_i[11:0];
  assign in_word   = s_tdata_i[43:12];
  assign in_acc    = s_tvalid_i && s_tready_o;
  assign fifo_word = ram_rdata;

  vcfp_ram #(
    .Width(32),
    .Depth(vcfp_pkg::FifoDepth)
  ) u_fifo_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(head_q),
    .wdata_i(in_word),
    .re_i   (ram_re),
    .raddr_i(tail_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    fill_d    = fill_q;
    param_d   = param_q;
    held_op_d = held_op_q;
    blank_d   = blank_q;
    wait_a_d  = wait_a_q;
    wait_b_d  = wait_b_q;
    front_a_d = front_a_q;
    back_a_d  = back_a_q;
    front_b_d = front_b_q;
    back_b_d  = back_b_q;
    mode_d    = mode_q;
    scan_d    = scan_q;
    pix_d     = pix_q;
    mix_d     = mix_q;
    rd_d      = rd_q;
    ovf_d     = ovf_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    out_load  = 1'b0;
    s_tready_o = 1'b0;
    m_valid_d = m_valid_q && !m_tready_i;

    case (state_q)
      vcfp_pkg::StIdle: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          rd_d  = '0;
          ovf_d = 1'b0;
          case (vcfp_pkg::bus_op_e'(s_tuser_i))
            vcfp_pkg::OpWrite: begin
              if (fill_q < FillW'(vcfp_pkg::FifoDepth)) begin
                ram_we = 1'b1;
                head_d = vcfp_pkg::ptr_inc(head_q);
                fill_d = fill_q + FillW'(1);
              end else begin
                ovf_d = 1'b1;
              end
              state_d = vcfp_pkg::StDrain;
            end
            vcfp_pkg::OpRead: begin
              if (in_offset == 12'd0) begin
                rd_d[vcfp_pkg::StatBlankBit] = blank_q;
                rd_d[vcfp_pkg::StatFifoBit]  = (fill_q != '0);
              end
              state_d = vcfp_pkg::StResult;
            end
            vcfp_pkg::OpVsync: begin
              blank_d = !blank_q;
              if (wait_a_q) begin
                front_a_d = back_a_q;
                back_a_d  = front_a_q;
                wait_a_d  = 1'b0;
              end
              if (wait_b_q) begin
                front_b_d = back_b_q;
                back_b_d  = front_b_q;
                wait_b_d  = 1'b0;
              end
              state_d = vcfp_pkg::StDrain;
            end
            default: begin
              state_d = vcfp_pkg::StResult;
            end
          endcase
        end
      end

      vcfp_pkg::StDrain: begin
        // fetch the oldest word unless the fifo is empty or a swap holds the queue
        if (fill_q != '0 && !wait_a_q && !wait_b_q) begin
          ram_re  = 1'b1;
          tail_d  = vcfp_pkg::ptr_inc(tail_q);
          fill_d  = fill_q - FillW'(1);
          state_d = vcfp_pkg::StDrainWait;
        end else begin
          state_d = vcfp_pkg::StResult;
        end
      end

      vcfp_pkg::StDrainWait: begin
        state_d = vcfp_pkg::StDrain;
        if (param_q) begin
          param_d = 1'b0;
          case (held_op_q)
            vcfp_pkg::CmdFrontA: front_a_d = fifo_word;
            vcfp_pkg::CmdMode:   mode_d    = fifo_word;
            vcfp_pkg::CmdScan:   scan_d    = fifo_word;
            vcfp_pkg::CmdPix:    pix_d     = fifo_word;
            vcfp_pkg::CmdBackA:  back_a_d  = fifo_word;
            vcfp_pkg::CmdFrontB: front_b_d = fifo_word;
            vcfp_pkg::CmdBackB:  back_b_d  = fifo_word;
            default: ;
          endcase
        end else begin
          case (fifo_word[7:0])
            vcfp_pkg::CmdFrontA, vcfp_pkg::CmdMode, vcfp_pkg::CmdCache,
            vcfp_pkg::CmdScan, vcfp_pkg::CmdPix, vcfp_pkg::CmdBackA,
            vcfp_pkg::CmdFrontB, vcfp_pkg::CmdBackB: begin
              held_op_d = fifo_word[7:0];
              param_d   = 1'b1;
            end
            vcfp_pkg::CmdSwapA: begin
              if (fifo_word[vcfp_pkg::SwapNowBit]) begin
                front_a_d = back_a_q;
                back_a_d  = front_a_q;
              end else begin
                wait_a_d = 1'b1;
              end
            end
            vcfp_pkg::CmdSwapB: begin
              if (fifo_word[vcfp_pkg::SwapNowBit]) begin
                front_b_d = back_b_q;
                back_b_d  = front_b_q;
              end else begin
                wait_b_d = 1'b1;
              end
            end
            vcfp_pkg::CmdMix: begin
              mix_d = fifo_word[27:8];
            end
            default: ;
          endcase
        end
      end

      vcfp_pkg::StResult: begin
        // snapshot into the output register once it is free
        if (!m_valid_q || m_tready_i) begin
          out_load  = 1'b1;
          m_valid_d = 1'b1;
          state_d   = vcfp_pkg::StIdle;
        end
      end

      default: begin
        state_d = vcfp_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= vcfp_pkg::StIdle;
      head_q    <= '0;
      tail_q    <= '0;
      fill_q    <= '0;
      param_q   <= 1'b0;
      held_op_q <= '0;
      blank_q   <= 1'b0;
      wait_a_q  <= 1'b0;
      wait_b_q  <= 1'b0;
      front_a_q <= vcfp_pkg::PageReset;
      back_a_q  <= '0;
      front_b_q <= vcfp_pkg::PageReset;
      back_b_q  <= '0;
      mode_q    <= vcfp_pkg::ModeReset;
      scan_q    <= '0;
      pix_q     <= '0;
      mix_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      fill_q    <= fill_d;
      param_q   <= param_d;
      held_op_q <= held_op_d;
      blank_q   <= blank_d;
      wait_a_q  <= wait_a_d;
      wait_b_q  <= wait_b_d;
      front_a_q <= front_a_d;
      back_a_q  <= back_a_d;
      front_b_q <= front_b_d;
      back_b_q  <= back_b_d;
      mode_q    <= mode_d;
      scan_q    <= scan_d;
      pix_q     <= pix_d;
      mix_q     <= mix_d;
      m_valid_q <= m_valid_d;
    end
  end

  // result pieces and output payload carry no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q  <= rd_d;
      ovf_q <= ovf_d;
    end
    if (out_load) begin
      m_data_q <= {3'b000, ovf_q, mix_q, pix_q, scan_q, mode_q,
                   back_b_q, front_b_q, back_a_q, front_a_q, rd_q};
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

endmodule

// ===== hw/rtl/vcfp_checker.sv =====
// vcfp_checker: port level assertions of the video command front end and its bind
`timescale 1ns / 1ps

module vcfp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_tvalid_i,
  input logic                          s_tready_o,
  input logic [vcfp_pkg::InDataW-1:0]  s_tdata_i,
  input logic [vcfp_pkg::InUserW-1:0]  s_tuser_i,
  input logic                          m_tvalid_o,
  input logic                          m_tready_i,
  input logic [vcfp_pkg::OutDataW-1:0] m_tdata_o
);

  // a stalled result stays valid
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> $stable(m_tdata_o))
    else $error("result payload changed while stalled");

  // one transaction in work at a time
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("input taken while previous one still in work");

  // status word only uses blank and fifo bits, and an overflow comes with no status
  a_status_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> ((m_tdata_o[31:0] & ~32'h0000_0801) == 32'd0) &&
                   (!m_tdata_o[276] || (m_tdata_o[31:0] == 32'd0)))
    else $error("malformed status or overflow result");

endmodule

bind video_command_fifo_processor_unit vcfp_checker u_vcfp_checker (.*);
